>>> rtl/anc_pkg.sv
`default_nettype none

package anc_pkg;

  // Table geometry
  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int OCC_W   = $clog2(ENTRIES + 1);

  // Field widths
  localparam int OP_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int HANDLE_W = 64;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 32;
  localparam int USED_W   = 7;
  localparam int TTL_W    = 16;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(300);
  localparam logic [0:0] REG_TTL = 1'b0;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OP_W-1:0] OP_FILL   = 2'd1;
  localparam logic [OP_W-1:0] OP_SWEEP  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LOOKUP_MISS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FILLED      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SWEPT       = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [ADDR_W-1:0]   address;
    logic [HANDLE_W-1:0] name_handle;
    logic [TIME_W-1:0]   now;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] value;
    logic [COUNT_W-1:0]  hit_count;
    logic [COUNT_W-1:0]  miss_count;
    logic [COUNT_W-1:0]  full_count;
    logic [USED_W-1:0]   entries_used;
  } res_t;

  // One table entry as stored in the entry RAM
  typedef struct packed {
    logic [ADDR_W-1:0]   key;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   stamp;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/anc_if.sv
`default_nettype none

interface anc_in_if import anc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ADDR_W-1:0]   address;
  logic [HANDLE_W-1:0] name_handle;
  logic [TIME_W-1:0]   now;

  modport source (output valid, operation, address, name_handle, now, input ready);
  modport sink   (input valid, operation, address, name_handle, now, output ready);
endinterface

interface anc_out_if import anc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] value;
  logic [COUNT_W-1:0]  hit_count;
  logic [COUNT_W-1:0]  miss_count;
  logic [COUNT_W-1:0]  full_count;
  logic [USED_W-1:0]   entries_used;

  modport source (output valid, status, value, hit_count, miss_count, full_count,
                  entries_used, input ready);
  modport sink   (input valid, status, value, hit_count, miss_count, full_count,
                  entries_used, output ready);
endinterface

`default_nettype wire

>>> rtl/anc_ram.sv
`default_nettype none

module anc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> rtl/anc_engine.sv
`default_nettype none

module anc_engine import anc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire item_t            req_item,
  input  wire logic [TTL_W-1:0] ttl,
  output logic                  res_valid,
  output res_t                  res,
  input  wire logic             res_taken
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_COMMIT,
    S_HOLD
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(ENTRIES);

  state_t              state_r;
  item_t               item_r;
  logic                sweep_en_r;
  logic [TIME_W-1:0]   limit_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                eval_vld_r;
  logic [IDX_W-1:0]    eval_idx_r;
  logic                found_r;
  logic [IDX_W-1:0]    hit_idx_r;
  logic [HANDLE_W-1:0] hit_handle_r;
  logic [TIME_W-1:0]   best_r;
  logic [IDX_W-1:0]    slot_r;
  logic                slot_ok_r;
  logic [ENTRIES-1:0]  valid_r;
  logic [OCC_W-1:0]    occ_r;
  logic [COUNT_W-1:0]  hits_r;
  logic [COUNT_W-1:0]  misses_r;
  logic [COUNT_W-1:0]  fulls_r;
  res_t                res_r;

  logic                accept;
  entry_t              rd_entry;
  logic [$bits(entry_t)-1:0] rd_raw;
  logic                ev_valid;
  logic [TIME_W-1:0]   ev_stamp;
  logic                ev_match;
  logic                ev_better;
  logic                ev_clear;

  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  entry_t              mem_wdata;
  logic [STATUS_W-1:0] cmt_status;
  logic [HANDLE_W-1:0] cmt_value;
  logic                cmt_hit;
  logic                cmt_miss;
  logic                cmt_full;
  logic                cmt_fill;
  logic                cmt_occ_inc;

  logic [COUNT_W-1:0]  hits_nxt;
  logic [COUNT_W-1:0]  misses_nxt;
  logic [COUNT_W-1:0]  fulls_nxt;
  logic [OCC_W-1:0]    occ_nxt;

  assign req_ready = (state_r == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign res_valid = (state_r == S_HOLD);
  assign res       = res_r;

  // Entry RAM: key, handle and timestamp of each entry
  anc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx_r),
    .rdata (rd_raw)
  );

  assign rd_entry = entry_t'(rd_raw);

  // Examine the entry returned by the RAM this cycle
  always_comb begin
    ev_valid  = valid_r[eval_idx_r];
    ev_stamp  = ev_valid ? rd_entry.stamp : '0;
    ev_match  = eval_vld_r && ev_valid && (rd_entry.key == item_r.address);
    ev_better = eval_vld_r && (ev_stamp < best_r);
    ev_clear  = eval_vld_r && sweep_en_r && ev_valid && (rd_entry.stamp < limit_r);
  end

  // Decide the outcome once the whole table has been seen
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_r;
    mem_wdata   = '{key: item_r.address, handle: hit_handle_r, stamp: item_r.now};
    cmt_status  = ST_LOOKUP_MISS;
    cmt_value   = item_r.name_handle;
    cmt_hit     = 1'b0;
    cmt_miss    = 1'b0;
    cmt_full    = 1'b0;
    cmt_fill    = 1'b0;
    cmt_occ_inc = 1'b0;
    case (item_r.operation)
      OP_LOOKUP, OP_FILL: begin
        if (found_r) begin
          // Hit: return the stored handle and refresh the stamp unless now is zero
          cmt_hit    = 1'b1;
          cmt_status = ST_HIT;
          cmt_value  = hit_handle_r;
          mem_we     = (item_r.now != '0);
        end else if (item_r.operation == OP_FILL) begin
          cmt_miss = 1'b1;
          if (!slot_ok_r || (occ_r >= FULL_OCC)) begin
            cmt_full   = 1'b1;
            cmt_status = ST_FULL;
          end else begin
            cmt_fill    = 1'b1;
            cmt_status  = ST_FILLED;
            cmt_occ_inc = !valid_r[slot_r];
            mem_we      = 1'b1;
            mem_waddr   = slot_r;
            mem_wdata   = '{key: item_r.address, handle: item_r.name_handle,
                            stamp: item_r.now};
          end
        end
      end
      OP_SWEEP: begin
        cmt_status = ST_SWEPT;
      end
      default: begin
        cmt_status = ST_LOOKUP_MISS;
      end
    endcase
    if (state_r != S_COMMIT) begin
      mem_we = 1'b0;
    end
  end

  // Counter updates
  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    fulls_nxt  = fulls_r;
    occ_nxt    = occ_r;
    if (state_r == S_COMMIT) begin
      hits_nxt   = hits_r + COUNT_W'(cmt_hit);
      misses_nxt = misses_r + COUNT_W'(cmt_miss);
      fulls_nxt  = fulls_r + COUNT_W'(cmt_full);
      occ_nxt    = occ_r + OCC_W'(cmt_occ_inc);
    end else if (ev_clear) begin
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  // Sequencer: latch item, scan the table, commit, hand off the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      eval_vld_r <= 1'b0;
      valid_r    <= '0;
      occ_r      <= '0;
      hits_r     <= '0;
      misses_r   <= '0;
      fulls_r    <= '0;
      rd_idx_r   <= '0;
    end else begin
      hits_r     <= hits_nxt;
      misses_r   <= misses_nxt;
      fulls_r    <= fulls_nxt;
      occ_r      <= occ_nxt;
      eval_vld_r <= (state_r == S_SCAN);
      eval_idx_r <= rd_idx_r;

      // Track the first match and the oldest slot below now
      if (ev_match && !found_r) begin
        found_r      <= 1'b1;
        hit_idx_r    <= eval_idx_r;
        hit_handle_r <= rd_entry.handle;
      end
      if (ev_better) begin
        best_r    <= ev_stamp;
        slot_r    <= eval_idx_r;
        slot_ok_r <= 1'b1;
      end
      if (ev_clear) begin
        valid_r[eval_idx_r] <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            item_r     <= req_item;
            sweep_en_r <= (req_item.operation == OP_SWEEP) &&
                          (req_item.now >= TIME_W'(ttl));
            limit_r    <= req_item.now - TIME_W'(ttl);
            best_r     <= req_item.now;
            found_r    <= 1'b0;
            slot_ok_r  <= 1'b0;
            rd_idx_r   <= '0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx_r == LAST_IDX) begin
            state_r <= S_TAIL;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        S_TAIL: begin
          state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (cmt_fill) begin
            valid_r[slot_r] <= 1'b1;
          end
          res_r.status       <= cmt_status;
          res_r.value        <= cmt_value;
          res_r.hit_count    <= hits_nxt;
          res_r.miss_count   <= misses_nxt;
          res_r.full_count   <= fulls_nxt;
          res_r.entries_used <= USED_W'(occ_nxt);
          state_r            <= S_HOLD;
        end
        S_HOLD: begin
          if (res_taken) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Occupancy never exceeds the table size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_OCC)
    else $error("occupancy above table size");

  // Occupancy tracks the live entries
  a_occ_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(occ_r))
    else $error("occupancy out of step with valid bits");

  // An accepted item starts a table scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN) && (rd_idx_r == '0))
    else $error("accepted item did not start a scan");

  // The table is written only at commit
  a_write_commit: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_COMMIT) && !eval_vld_r)
    else $error("table write outside commit");

endmodule

`default_nettype wire

>>> rtl/address_name_cache_with_ttl_core.sv
`default_nettype none

// Address-to-name cache with TTL expiry. A fully associative table of 64
// entries maps a 32-bit address to a 64-bit name handle and a timestamp.
// Every word (lookup, fill or sweep) walks the whole entry RAM through its
// single read port, one entry per cycle, then commits at most one write, and
// no new word is accepted until that result has left the engine. The result
// is held in an output register, so the next word is taken while a result
// waits. Empty entries are tracked by valid bits that reset clears at once:
// no clearing pass runs after reset. The TTL register (seconds, reset 300)
// sits at byte address 0 of the APB port and should only be written while
// the core is idle.

module address_name_cache_with_ttl_core import anc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  anc_in_if.sink                 in_if,
  anc_out_if.source              out_if,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic [TTL_W-1:0] ttl_r;
  logic             cfg_wr;
  item_t            req_item;
  logic             req_ready;
  logic             res_valid;
  res_t             res;
  logic             res_load;
  logic             out_vld_r;
  res_t             out_res_r;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_TTL);
  assign prdata = (paddr[APB_AW-1] == REG_TTL) ? APB_DW'(ttl_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_wr) begin
      ttl_r <= pwdata[TTL_W-1:0];
    end
  end

  // Input word
  assign req_item = '{operation:   in_if.operation,
                      address:     in_if.address,
                      name_handle: in_if.name_handle,
                      now:         in_if.now};
  assign in_if.ready = req_ready;

  anc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_if.valid),
    .req_ready (req_ready),
    .req_item  (req_item),
    .ttl       (ttl_r),
    .res_valid (res_valid),
    .res       (res),
    .res_taken (res_load)
  );

  // Output register: load when empty or being drained
  assign res_load = res_valid && (!out_vld_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (res_load) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.status       = out_res_r.status;
  assign out_if.value        = out_res_r.value;
  assign out_if.hit_count    = out_res_r.hit_count;
  assign out_if.miss_count   = out_res_r.miss_count;
  assign out_if.full_count   = out_res_r.full_count;
  assign out_if.entries_used = out_res_r.entries_used;

endmodule

`default_nettype wire
